### rtl/occ_pkg.sv
package occ_pkg;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_START = 3'd1,
		OP_LONG  = 3'd2,
		OP_SHORT = 3'd3,
		OP_ADC   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		PH_CHOOSE = 2'd0,
		PH_RUN    = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		REG_LONG  = 3'd0,
		REG_SHORT = 3'd1,
		REG_TPS   = 3'd2,
		REG_HEAT  = 3'd3,
		REG_HOLD  = 3'd4
	} cfg_reg_t;

	localparam logic [2:0] LV_START = 3'b001;
	localparam logic [2:0] LV_LONG  = 3'b010;
	localparam logic [2:0] LV_SHORT = 3'b100;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 7;

	localparam int ADC_SCALE = 1000;
	localparam logic [9:0] TEMP_MAX = 10'd1000;
	localparam logic [6:0] TIME_MAX = 7'd99;

	localparam int M_FIELDS_W = 49;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	typedef struct packed {
		phase_t     phase;
		logic [6:0] chosen;
		logic [6:0] remaining;
		logic       heater;
		logic [9:0] temp;
		logic       changed;
	} res_t;

	function automatic logic [6:0] cap99(input logic [6:0] v);
		cap99 = (v > TIME_MAX) ? TIME_MAX : v;
	endfunction

endpackage

### rtl/occ_ingress.sv
module occ_ingress #(
	parameter int ADC_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [2:0] button_levels, [3 +: ADC_BITS] adc_value, zero fill above
	input  logic [((ADC_BITS+10)/8)*8-1:0] s_tdata,
	// [2:0] operation
	input  logic [2:0]                     s_tuser,
	input  logic                           take,
	output logic                           valid_s1,
	output occ_pkg::op_t                   op_s1,
	output logic [2:0]                     lv_s1,
	output logic [ADC_BITS+9:0]            prod_s1
);
	import occ_pkg::*;

	localparam int XW = ADC_BITS + 10;

	logic [XW-1:0] prod;

	assign prod     = XW'(s_tdata[3 +: ADC_BITS]) * XW'(ADC_SCALE);
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= op_t'(s_tuser);
			lv_s1   <= s_tdata[2:0];
			prod_s1 <= prod;
		end
	end

endmodule

### rtl/occ_core.sv
module occ_core #(
	parameter int ADC_BITS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid_s1,
	input  occ_pkg::op_t                         op_s1,
	input  logic [2:0]                           lv_s1,
	input  logic [ADC_BITS+9:0]                  prod_s1,
	output logic                                 take,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [occ_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [occ_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output occ_pkg::res_t                        res_s2
);
	import occ_pkg::*;

	localparam int XW = ADC_BITS + 10;
	localparam int QW = XW + 1 - ADC_BITS;
	localparam logic [XW:0] FULL = (XW+1)'((2 ** ADC_BITS) - 1);

	logic [6:0] long_q, short_q, heat_q;
	logic [3:0] tps_q;
	logic [5:0] hold_lim_q;

	phase_t     phase_q, phase_d;
	logic [6:0] rem_q, rem_d, chosen_q, chosen_d;
	logic [3:0] ps_q, ps_d, ps_inc;
	logic [5:0] hold_q, hold_d;
	logic       heater_q, heater_d;
	logic [9:0] temp_q, temp_d;
	logic       chg;
	logic       valid_s2;

	logic [XW:0]   y, qf;
	logic [QW-1:0] q, qc;
	logic [9:0]    t;
	logic [10:0]   heat_lim;

	assign cfg_ready = 1'b1;
	assign take      = valid_s1 && (!valid_s2 || m_tready);
	assign m_tvalid  = valid_s2;

	// tenths = prod / (2^ADC_BITS - 1): series estimate, one correction step
	always_comb begin
		y  = {1'b0, prod_s1} + (XW+1)'(prod_s1 >> ADC_BITS)
			+ (XW+1)'(prod_s1 >> (2 * ADC_BITS));
		q  = y[XW:ADC_BITS];
		qf = {q, ADC_BITS'(0)} - (XW+1)'(q);
		qc = ({1'b0, prod_s1} >= qf + FULL) ? q + QW'(1) : q;
		t  = (qc > QW'(TEMP_MAX)) ? TEMP_MAX : qc[9:0];
		heat_lim = (11'(heat_q) + 11'd1) * 11'd10;
	end

	always_comb begin
		phase_d  = phase_q;
		rem_d    = rem_q;
		chosen_d = chosen_q;
		ps_d     = ps_q;
		hold_d   = hold_q;
		heater_d = heater_q;
		temp_d   = temp_q;
		chg      = 1'b0;
		ps_inc   = ps_q + 4'd1;
		unique case (op_s1)
			OP_TICK: begin
				if (phase_q == PH_RUN) begin
					if (ps_inc >= tps_q) begin
						ps_d = 4'd0;
						if (rem_q != 7'd0) begin
							rem_d = rem_q - 7'd1;
							chg   = 1'b1;
						end
						if (rem_q <= 7'd1) begin
							heater_d = 1'b0;
							phase_d  = PH_DONE;
							hold_d   = 6'd0;
							chg      = 1'b1;
						end
					end else begin
						ps_d = ps_inc;
					end
				end else if (phase_q == PH_DONE) begin
					if (7'(hold_q) + 7'd1 >= 7'(hold_lim_q)) begin
						phase_d  = PH_CHOOSE;
						chosen_d = 7'd0;
						hold_d   = 6'd0;
						chg      = 1'b1;
					end else begin
						hold_d = hold_q + 6'd1;
					end
				end
			end
			OP_START: begin
				if (lv_s1 == LV_START && phase_q == PH_CHOOSE && chosen_q != 7'd0) begin
					rem_d   = chosen_q;
					phase_d = PH_RUN;
					chg     = 1'b1;
				end
			end
			OP_LONG: begin
				if (lv_s1 == LV_LONG && phase_q == PH_CHOOSE) begin
					chosen_d = cap99(long_q);
					chg      = 1'b1;
				end
			end
			OP_SHORT: begin
				if (lv_s1 == LV_SHORT && phase_q == PH_CHOOSE) begin
					chosen_d = cap99(short_q);
					chg      = 1'b1;
				end
			end
			OP_ADC: begin
				if (phase_q == PH_RUN) begin
					temp_d   = t;
					heater_d = 11'(t) >= heat_lim;
					chg      = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q     <= 7'd60;
			short_q    <= 7'd15;
			tps_q      <= 4'd4;
			heat_q     <= 7'd50;
			hold_lim_q <= 6'd8;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LONG:  long_q     <= cfg_data[6:0];
				REG_SHORT: short_q    <= cfg_data[6:0];
				REG_TPS:   tps_q      <= cfg_data[3:0];
				REG_HEAT:  heat_q     <= cfg_data[6:0];
				REG_HOLD:  hold_lim_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CHOOSE;
			rem_q    <= 7'd0;
			chosen_q <= 7'd0;
			ps_q     <= 4'd0;
			hold_q   <= 6'd0;
			heater_q <= 1'b0;
			temp_q   <= 10'd0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				phase_q  <= phase_d;
				rem_q    <= rem_d;
				chosen_q <= chosen_d;
				ps_q     <= ps_d;
				hold_q   <= hold_d;
				heater_q <= heater_d;
				temp_q   <= temp_d;
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s2.phase     <= phase_d;
			res_s2.chosen    <= chosen_d;
			res_s2.remaining <= rem_d;
			res_s2.heater    <= heater_d;
			res_s2.temp      <= temp_d;
			res_s2.changed   <= chg;
		end
	end

	a_run_has_time: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RUN |-> rem_q != 7'd0)
		else $error("running with no time left");

	a_heater_only_run: assert property (@(posedge clk) disable iff (!arst_n)
		heater_q |-> phase_q == PH_RUN)
		else $error("heater on outside running");

	a_choose_hold_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CHOOSE |-> hold_q == 6'd0)
		else $error("hold count left over in choose");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		temp_q <= TEMP_MAX)
		else $error("temperature above full scale");

endmodule

### rtl/occ_format.sv
module occ_format (
	input  occ_pkg::res_t                 res,
	output logic [occ_pkg::M_TDATA_W-1:0] m_tdata
);
	import occ_pkg::*;

	logic [14:0] rp;
	logic [3:0]  sec_tens, sec_units;
	logic [6:0]  sec_rest;
	logic [17:0] p1;
	logic [15:0] p2;
	logic [6:0]  q1;
	logic [3:0]  q2;
	logic [9:0]  dec_w;
	logic [6:0]  unit_w;
	logic        hund;
	logic [3:0]  t_tens, t_units, t_dec;

	always_comb begin
		rp        = 15'(res.remaining) * 15'd205;
		sec_tens  = rp[14:11];
		sec_rest  = res.remaining - 7'(sec_tens) * 7'd10;
		sec_units = sec_rest[3:0];

		p1     = 18'(res.temp) * 18'd205;
		p2     = 16'(res.temp) * 16'd41;
		q1     = p1[17:11];
		q2     = p2[15:12];
		dec_w  = res.temp - 10'(q1) * 10'd10;
		unit_w = q1 - 7'(q2) * 7'd10;
		hund   = res.temp >= TEMP_MAX;
		t_tens  = hund ? 4'd0 : q2;
		t_units = hund ? 4'd0 : unit_w[3:0];
		t_dec   = hund ? 4'd0 : dec_w[3:0];
	end

	assign m_tdata = {
		{(M_TDATA_W - M_FIELDS_W){1'b0}},
		res.changed, t_dec, t_units, t_tens, hund, res.temp, res.heater,
		sec_units, sec_tens, res.remaining, res.chosen, res.phase
	};

endmodule

### rtl/oven_countdown_controller.sv
// Oven countdown controller: choose a time, run the countdown, finish, then
// return to choose after a hold counted in ticks.
// Input channel s_*: one event per transfer. s_tuser carries the operation
// (tick, start, long, short, ADC sample); s_tdata carries button levels and
// the converter reading. Output channel m_*: exactly one result per event,
// in order, with phase, times, digits, heater, temperature and a change flag.
// Configuration channel cfg_*: register writes by index, always ready; write
// only while no event is in flight.
// An event passes through the input register, then the state update that loads
// the result register. Throughput: one event per cycle while the receiver accepts
// results, set by the state update loop.
// A stalled receiver holds the result register; one more event waits in the
// input register, and s_tready drops only when both are full.
// Reset clears phase, countdown, selection, prescaler, hold, heater and
// temperature, and loads the configuration defaults.
module oven_countdown_controller #(
	parameter int ADC_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [2:0] button_levels, [3 +: ADC_BITS] adc_value, zero fill above
	input  logic [((ADC_BITS+10)/8)*8-1:0]      s_tdata,
	// [2:0] operation
	input  logic [2:0]                          s_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [occ_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [occ_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] phase_now, [8:2] chosen_time, [15:9] seconds_left,
	// [19:16] seconds_tens, [23:20] seconds_units, [24] heater_on,
	// [34:25] temp_tenths_total, [35] temp_hundreds_digit,
	// [39:36] temp_tens_digit, [43:40] temp_units_digit,
	// [47:44] temp_decimal_digit, [48] screen_changed, zero fill above
	output logic [occ_pkg::M_TDATA_W-1:0]       m_tdata
);
	import occ_pkg::*;

	logic                  take;
	logic                  valid_s1;
	op_t                   op_s1;
	logic [2:0]            lv_s1;
	logic [ADC_BITS+9:0]   prod_s1;
	res_t                  res_s2;

	occ_ingress #(.ADC_BITS(ADC_BITS)) u_ingress (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (take),
		.valid_s1 (valid_s1),
		.op_s1    (op_s1),
		.lv_s1    (lv_s1),
		.prod_s1  (prod_s1)
	);

	occ_core #(.ADC_BITS(ADC_BITS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.op_s1     (op_s1),
		.lv_s1     (lv_s1),
		.prod_s1   (prod_s1),
		.take      (take),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res_s2    (res_s2)
	);

	occ_format u_format (
		.res     (res_s2),
		.m_tdata (m_tdata)
	);

endmodule

### tb/oven_countdown_controller_tb.sv
`timescale 1ns / 100ps

module oven_countdown_controller_tb;
	import occ_pkg::*;

	localparam int ADC_W = 10;
	localparam int ADC_FULL = (1 << ADC_W) - 1;
	localparam int S_TDATA_W = ((ADC_W + 10) / 8) * 8;

	typedef struct {
		logic [1:0] phase;
		logic [6:0] chosen;
		logic [6:0] left;
		logic [3:0] tens;
		logic [3:0] units;
		logic       heater;
		logic [9:0] tenths;
		logic       hund;
		logic [3:0] dig_tens;
		logic [3:0] dig_units;
		logic [3:0] dig_tenth;
		logic       changed;
	} oven_view_t;

	class oven_timer_board;
		logic [6:0] long_sec, short_sec, heat_limit;
		logic [3:0] tick_div;
		logic [5:0] hold_len;
		phase_t     phase;
		logic [6:0] remaining, chosen;
		logic [3:0] prescale;
		logic [5:0] hold_count;
		logic       heater;
		logic [9:0] last_temp;
		oven_view_t pending_views[$];
		int errors, results, events, runs_started, runs_finished, heat_views;

		function new();
			long_sec = 7'd60;
			short_sec = 7'd15;
			tick_div = 4'd4;
			heat_limit = 7'd50;
			hold_len = 6'd8;
			phase = PH_CHOOSE;
			remaining = '0;
			chosen = '0;
			prescale = '0;
			hold_count = '0;
			heater = 1'b0;
			last_temp = '0;
		endfunction

		function logic [6:0] time_cap(logic [6:0] v);
			return (v > TIME_MAX) ? TIME_MAX : v;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [6:0] v);
			case (idx)
				REG_LONG:  long_sec = v;
				REG_SHORT: short_sec = v;
				REG_TPS:   tick_div = v[3:0];
				REG_HEAT:  heat_limit = v;
				REG_HOLD:  hold_len = v[5:0];
				default: ;
			endcase
		endfunction

		// note one accepted event and queue the display it must produce
		function void advance_timer(logic [2:0] op, logic [2:0] levels, logic [9:0] adc);
			bit changed;
			int t;
			oven_view_t v;
			changed = 0;
			events++;
			case (op)
				OP_TICK: begin
					if (phase == PH_RUN) begin
						prescale = prescale + 4'd1;
						if (prescale >= tick_div) begin
							prescale = '0;
							if (remaining > 0) begin
								remaining = remaining - 7'd1;
								changed = 1;
							end
							if (remaining == 0) begin
								heater = 1'b0;
								phase = PH_DONE;
								hold_count = '0;
								changed = 1;
								runs_finished++;
							end
						end
					end else if (phase == PH_DONE) begin
						if (hold_count + 1 >= hold_len) begin
							phase = PH_CHOOSE;
							chosen = '0;
							hold_count = '0;
							changed = 1;
						end else begin
							hold_count = hold_count + 6'd1;
						end
					end
				end
				OP_START: begin
					if (levels == LV_START && phase == PH_CHOOSE && chosen != 0) begin
						remaining = chosen;
						phase = PH_RUN;
						changed = 1;
						runs_started++;
					end
				end
				OP_LONG: begin
					if (levels == LV_LONG && phase == PH_CHOOSE) begin
						chosen = time_cap(long_sec);
						changed = 1;
					end
				end
				OP_SHORT: begin
					if (levels == LV_SHORT && phase == PH_CHOOSE) begin
						chosen = time_cap(short_sec);
						changed = 1;
					end
				end
				OP_ADC: begin
					if (phase == PH_RUN) begin
						t = (int'(adc) * ADC_SCALE) / ADC_FULL;
						if (t > TEMP_MAX)
							t = int'(TEMP_MAX);
						last_temp = 10'(t);
						heater = ((t / 10) > heat_limit);
						changed = 1;
					end
				end
				default: ;
			endcase
			v.phase = phase;
			v.chosen = chosen;
			v.left = remaining;
			v.tens = 4'(remaining / 10);
			v.units = 4'(remaining % 10);
			v.heater = heater;
			v.tenths = last_temp;
			if (last_temp >= TEMP_MAX) begin
				v.hund = 1'b1;
				v.dig_tens = '0;
				v.dig_units = '0;
				v.dig_tenth = '0;
			end else begin
				v.hund = 1'b0;
				v.dig_tens = 4'((last_temp / 100) % 10);
				v.dig_units = 4'((last_temp / 10) % 10);
				v.dig_tenth = 4'(last_temp % 10);
			end
			v.changed = changed;
			if (heater)
				heat_views++;
			pending_views.push_back(v);
		endfunction

		function void compare(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				if (errors < 40)
					$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] word);
			oven_view_t w;
			if (pending_views.size() == 0) begin
				errors++;
				$display("%0t: result with no event pending, expected none, actual %h", $time, word);
				return;
			end
			w = pending_views.pop_front();
			results++;
			compare("phase_now", 16'(w.phase), 16'(word[1:0]));
			compare("chosen_time", 16'(w.chosen), 16'(word[8:2]));
			compare("seconds_left", 16'(w.left), 16'(word[15:9]));
			compare("seconds_tens", 16'(w.tens), 16'(word[19:16]));
			compare("seconds_units", 16'(w.units), 16'(word[23:20]));
			compare("heater_on", 16'(w.heater), 16'(word[24]));
			compare("temp_tenths_total", 16'(w.tenths), 16'(word[34:25]));
			compare("temp_hundreds_digit", 16'(w.hund), 16'(word[35]));
			compare("temp_tens_digit", 16'(w.dig_tens), 16'(word[39:36]));
			compare("temp_units_digit", 16'(w.dig_units), 16'(word[43:40]));
			compare("temp_decimal_digit", 16'(w.dig_tenth), 16'(word[47:44]));
			compare("screen_changed", 16'(w.changed), 16'(word[48]));
			compare("zero fill", '0, 16'(word[M_TDATA_W-1:49]));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic [2:0]             s_tuser;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;

	oven_timer_board board;
	int  burst_left;
	int  gap_max;
	int  stall_pct;
	int  stall_left;
	bit  long_stall_req;
	int  items_sent;
	int  config_sets;

	oven_countdown_controller #(.ADC_BITS(ADC_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	// receiver: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (long_stall_req) begin
			stall_left = 300;
			long_stall_req = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	task automatic send_event(logic [2:0] op, logic [2:0] levels, logic [9:0] adc);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(S_TDATA_W - ADC_W - 3){1'b0}}, adc, levels};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.advance_timer(op, levels, adc);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			if (gap_max > 0) begin
				gap = $urandom_range(1, gap_max);
				s_tvalid <= 1'b0;
				s_tuser <= 3'($urandom);
				s_tdata <= S_TDATA_W'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_counted(logic [2:0] op, logic [2:0] levels, logic [9:0] adc);
		send_event(op, levels, adc);
		items_sent++;
	endtask

	task automatic send_noise();
		send_event(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 10'($urandom));
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending_views.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [6:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_reg(idx, value);
	endtask

	task automatic set_config(logic [6:0] lng, logic [6:0] sht, logic [6:0] tps,
			logic [6:0] heat, logic [6:0] hold);
		wait_drain();
		repeat (4) @(posedge clk);
		write_reg(REG_LONG, lng);
		write_reg(REG_SHORT, sht);
		write_reg(REG_TPS, tps);
		write_reg(REG_HEAT, heat);
		write_reg(REG_HOLD, hold);
		cfg_valid <= 1'b0;
		config_sets++;
	endtask

	function automatic logic [9:0] pick_adc();
		int r, b;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return 10'(ADC_FULL);
		if (r == 2) begin
			// land near the heater switching point
			b = ((board.heat_limit + 1) * 10230 + 999) / 1000 - 1 + $urandom_range(0, 2);
			if (b > ADC_FULL)
				b = ADC_FULL;
			return 10'(b);
		end
		return 10'($urandom);
	endfunction

	// choose, start, ticks and samples through finish and hold; may stop early or send only noise
	task automatic run_session(int stop_at);
		bit use_long;
		int secs, div, ticks, r;
		use_long = $urandom_range(0, 1);
		secs = int'(board.time_cap(use_long ? board.long_sec : board.short_sec));
		div = (board.tick_div == 0) ? 1 : int'(board.tick_div);
		ticks = secs * div + ((board.hold_len == 0) ? 1 : int'(board.hold_len)) + 1;
		r = $urandom_range(0, 9);
		if (r == 9) begin
			repeat ($urandom_range(3, 12)) send_noise();
			return;
		end
		if (r == 8)
			ticks = $urandom_range(0, ticks / 2);
		if ($urandom_range(0, 3) == 0)
			send_counted(use_long ? OP_SHORT : OP_LONG, use_long ? LV_SHORT : LV_LONG,
				10'($urandom));
		send_counted(use_long ? OP_LONG : OP_SHORT, use_long ? LV_LONG : LV_SHORT,
			10'($urandom));
		send_counted(OP_START, LV_START, 10'($urandom));
		while (ticks > 0 && board.events < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_counted(OP_TICK, 3'($urandom), 10'($urandom));
				ticks--;
			end else if (r < 93) begin
				send_counted(OP_ADC, 3'($urandom), pick_adc());
			end else begin
				send_noise();
			end
		end
	endtask

	task automatic run_phase(int target, int stall, int gapmax, bit hold_off, bit pause);
		int start, sessions;
		stall_pct = stall;
		gap_max = gapmax;
		start = board.events;
		sessions = 0;
		if (hold_off)
			long_stall_req = 1;
		while (board.events - start < target) begin
			run_session(start + target);
			sessions++;
			if (pause && sessions == 2)
				wait_drain();
		end
	endtask

	task automatic directed_events();
		send_counted(OP_TICK, '0, '0);
		send_counted(OP_START, LV_START, '0);
		send_counted(OP_ADC, '0, 10'(ADC_FULL));
		for (int c = OP_ADC + 1; c < 8; c++)
			send_counted(3'(c), '1, 10'(ADC_FULL));
		send_counted(OP_LONG, LV_LONG | LV_START, '0);
		send_counted(OP_LONG, LV_LONG, '0);
		send_counted(OP_SHORT, LV_SHORT | LV_LONG, '0);
		send_counted(OP_SHORT, LV_SHORT, '0);
		send_counted(OP_START, LV_START | LV_SHORT, '0);
		send_counted(OP_START, '0, '0);
		send_counted(OP_START, LV_START, '0);
		send_counted(OP_LONG, LV_LONG, '0);
		send_counted(OP_ADC, '0, '0);
		send_counted(OP_ADC, '1, 10'(ADC_FULL));
		send_counted(OP_ADC, '0, 10'(ADC_FULL - 1));
		send_counted(OP_ADC, '0, 10'h200);
		send_counted(OP_ADC, '0, 10'h2AA);
		send_counted(OP_ADC, '0, 10'h155);
		repeat (4) send_counted(OP_TICK, '0, '0);
		send_counted(OP_START, LV_START, '0);
	endtask

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int waited;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_tready = 1'b0;
		stall_left = 0;
		long_stall_req = 0;
		burst_left = 0;
		gap_max = 0;
		stall_pct = 0;
		items_sent = 0;
		config_sets = 1;
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		stall_pct = 25;
		gap_max = 2;
		directed_events();
		run_phase(200, 25, 3, 0, 0);

		set_config(7'd3, 7'd1, 7'd1, 7'd0, 7'd0);
		run_phase(300, 20, 3, 1, 1);

		set_config(7'd127, 7'd99, 7'd0, 7'd100, 7'd1);
		run_phase(300, 50, 0, 0, 0);

		set_config(7'd2, 7'd1, 7'd15, 7'd63, 7'd63);
		run_phase(300, 0, 5, 0, 0);

		repeat (5) begin
			set_config(7'($urandom_range(1, 12)), 7'($urandom_range(1, 12)),
				7'($urandom_range(0, 3)), 7'($urandom_range(0, 100)),
				7'($urandom_range(0, 10)));
			run_phase(150, $urandom_range(0, 60), $urandom_range(0, 6), 0, 0);
		end

		s_tvalid <= 1'b0;
		waited = 0;
		while (board.pending_views.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (board.pending_views.size() != 0) begin
			board.errors += board.pending_views.size();
			$display("%0t: %0d results never arrived", $time, board.pending_views.size());
		end

		$display("Ran %0d events (%0d in well-formed sequences), %0d results checked, %0d settings.",
			board.events, items_sent, board.results, config_sets);
		$display("Countdowns started %0d, finished %0d; %0d results with heater on.",
			board.runs_started, board.runs_finished, board.heat_views);
		if (board.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/occ_pkg.sv
rtl/occ_ingress.sv
rtl/occ_core.sv
rtl/occ_format.sv
rtl/oven_countdown_controller.sv
tb/oven_countdown_controller_tb.sv
